// ===== src/minmax_display_decimator_assert.svh =====
// Assertion macros shared by the RTL; they compile to nothing when SYNTH is set.
`ifndef MINMAX_DISPLAY_DECIMATOR_ASSERT_SVH
`define MINMAX_DISPLAY_DECIMATOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define MMDD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("minmax_display_decimator: assertion failed");
// Next-cycle implication, checked outside reset.
`define MMDD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("minmax_display_decimator: assertion failed");
`else
`define MMDD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define MMDD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== src/mmdd_pkg.sv =====
package mmdd_pkg;

    localparam int INDEX_BITS_DEF  = 24;
    localparam int SAMPLE_BITS_DEF = 32;

    // Column ratio is unsigned Q0.24
    localparam int RATIO_BITS = 24;
    localparam logic [RATIO_BITS-1:0] RATIO_HALF = 24'h800000;
    localparam logic [RATIO_BITS-1:0] PPS_RESET  = 24'h800000;

    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_START_INDEX       = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PIXELS_PER_SAMPLE = 2'd1;

    // Points per input beat: four for a closed column plus one on a flush
    localparam int MAX_POINTS = 5;
    localparam int PTR_BITS   = 3;
    localparam logic [PTR_BITS-1:0] MAX_COUNT = 3'd5;

    typedef struct packed {
        logic valid;
        logic first;   // first sample of a trace
        logic last;    // end_of_trace
    } beat_ctl_t;

    typedef struct packed {
        logic                load;
        logic [PTR_BITS-1:0] count;
        logic [PTR_BITS-1:0] split;  // points before this use the closed column's anchor
    } rec_ctl_t;

    typedef struct packed {
        logic                busy;
        logic [PTR_BITS-1:0] ptr;
        logic [PTR_BITS-1:0] count;
    } emit_status_t;

endpackage

// ===== src/mmdd_front.sv =====
module mmdd_front #(
    parameter int INDEX_BITS  = mmdd_pkg::INDEX_BITS_DEF,
    parameter int SAMPLE_BITS = mmdd_pkg::SAMPLE_BITS_DEF,
    localparam int ProdBits   = INDEX_BITS + mmdd_pkg::RATIO_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  logic                                s_valid,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample_value,
    input  logic                                s_end_of_trace,
    input  logic [INDEX_BITS-1:0]               start_index,
    input  logic [mmdd_pkg::RATIO_BITS-1:0]     pixels_per_sample,
    output mmdd_pkg::beat_ctl_t                 ctl_o,
    output logic [ProdBits-1:0]                 prod_o,
    output logic [INDEX_BITS-1:0]               idx_o,
    output logic signed [SAMPLE_BITS-1:0]       value_o,
    output logic                                primed_o
);

    logic                          primed_reg;
    logic [INDEX_BITS-1:0]         cnt_reg;
    logic [INDEX_BITS-1:0]         idx_next;
    logic [INDEX_BITS-1:0]         delta;
    mmdd_pkg::beat_ctl_t           s0_ctl_reg;
    logic [INDEX_BITS-1:0]         s0_idx_reg;
    logic signed [SAMPLE_BITS-1:0] s0_val_reg;
    mmdd_pkg::beat_ctl_t           s1_ctl_reg;
    logic [ProdBits-1:0]           s1_prod_reg;
    logic [INDEX_BITS-1:0]         s1_idx_reg;
    logic signed [SAMPLE_BITS-1:0] s1_val_reg;

    // A trace restarts at start_index, later samples take the next index
    assign idx_next = primed_reg ? cnt_reg + INDEX_BITS'(1) : start_index;
    assign delta    = s0_idx_reg - start_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
            s0_ctl_reg <= '0;
            s1_ctl_reg <= '0;
        end else if (advance) begin
            s0_ctl_reg.valid <= s_valid;
            s0_ctl_reg.first <= !primed_reg;
            s0_ctl_reg.last  <= s_end_of_trace;
            if (s_valid) begin
                primed_reg <= !s_end_of_trace;
            end
            s1_ctl_reg <= s0_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (s_valid) begin
                cnt_reg <= idx_next;
            end
            s0_idx_reg  <= idx_next;
            s0_val_reg  <= s_sample_value;
            s1_prod_reg <= ProdBits'(delta) * ProdBits'(pixels_per_sample);
            s1_idx_reg  <= s0_idx_reg;
            s1_val_reg  <= s0_val_reg;
        end
    end

    assign ctl_o    = s1_ctl_reg;
    assign prod_o   = s1_prod_reg;
    assign idx_o    = s1_idx_reg;
    assign value_o  = s1_val_reg;
    assign primed_o = primed_reg;

endmodule

// ===== src/mmdd_column.sv =====
module mmdd_column #(
    parameter int INDEX_BITS  = mmdd_pkg::INDEX_BITS_DEF,
    parameter int SAMPLE_BITS = mmdd_pkg::SAMPLE_BITS_DEF,
    localparam int ProdBits   = INDEX_BITS + mmdd_pkg::RATIO_BITS
) (
    input  logic                          aclk,
    input  logic                          advance,
    input  mmdd_pkg::beat_ctl_t           ctl_i,
    input  logic [ProdBits-1:0]           prod_i,
    input  logic [INDEX_BITS-1:0]         idx_i,
    input  logic signed [SAMPLE_BITS-1:0] value_i,
    output mmdd_pkg::rec_ctl_t            rec_o,
    output logic signed [SAMPLE_BITS-1:0] vals_o [mmdd_pkg::MAX_POINTS],
    output logic [INDEX_BITS-1:0]         anchor_old_o,
    output logic [INDEX_BITS-1:0]         anchor_new_o
);

    localparam int Cand = 8;

    logic [INDEX_BITS-1:0]         col_reg, col_next;
    logic [INDEX_BITS-1:0]         anchor_reg, anchor_next;
    logic signed [SAMPLE_BITS-1:0] first_reg, first_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [SAMPLE_BITS-1:0] last_reg, last_next;

    logic [INDEX_BITS-1:0]           quot;
    logic [mmdd_pkg::RATIO_BITS-1:0] frac;
    logic                            round_up;
    logic [INDEX_BITS-1:0]           col;
    logic                            change;
    logic                            open;
    logic signed [SAMPLE_BITS-1:0]   cand_val [Cand];
    logic                            cand_en  [Cand];
    logic [mmdd_pkg::PTR_BITS:0]     pos;
    logic [mmdd_pkg::PTR_BITS:0]     split;

    // Round to nearest, ties to even
    assign quot     = prod_i[ProdBits-1:mmdd_pkg::RATIO_BITS];
    assign frac     = prod_i[mmdd_pkg::RATIO_BITS-1:0];
    assign round_up = (frac > mmdd_pkg::RATIO_HALF) ||
                      ((frac == mmdd_pkg::RATIO_HALF) && quot[0]);
    assign col      = quot + INDEX_BITS'(round_up);

    assign change = !ctl_i.first && (col != col_reg);
    assign open   = ctl_i.first || change;

    always_comb begin
        if (open) begin
            col_next    = ctl_i.first ? '0 : col;
            anchor_next = idx_i;
            first_next  = value_i;
            min_next    = value_i;
            max_next    = value_i;
            last_next   = value_i;
        end else begin
            col_next    = col_reg;
            anchor_next = anchor_reg;
            first_next  = first_reg;
            min_next    = (value_i < min_reg) ? value_i : min_reg;
            max_next    = (value_i > max_reg) ? value_i : max_reg;
            last_next   = value_i;
        end
    end

    // Candidate points: closed column first, then the end-of-trace flush
    always_comb begin
        cand_val[0] = first_reg;
        cand_en[0]  = change;
        if (last_reg == min_reg) begin
            cand_val[1] = max_reg;
            cand_en[1]  = change && (max_reg != first_reg);
            cand_val[2] = min_reg;
            cand_en[2]  = change && (min_reg != max_reg);
            cand_val[3] = last_reg;
            cand_en[3]  = 1'b0;
        end else begin
            cand_val[1] = min_reg;
            cand_en[1]  = change && (min_reg != first_reg);
            cand_val[2] = max_reg;
            cand_en[2]  = change && (max_reg != min_reg);
            cand_val[3] = last_reg;
            cand_en[3]  = change && (last_reg != min_reg);
        end
        cand_val[4] = first_next;
        cand_en[4]  = ctl_i.last;
        cand_val[5] = min_next;
        cand_en[5]  = ctl_i.last && (min_next != first_next);
        cand_val[6] = max_next;
        cand_en[6]  = ctl_i.last && (max_next != min_next);
        cand_val[7] = last_next;
        cand_en[7]  = ctl_i.last && (last_next != min_next);
    end

    // Pack the enabled candidates
    always_comb begin
        pos   = '0;
        split = '0;
        for (int i = 0; i < mmdd_pkg::MAX_POINTS; i++) begin
            vals_o[i] = first_next;
        end
        for (int i = 0; i < Cand; i++) begin
            if (cand_en[i] && (pos < (mmdd_pkg::PTR_BITS + 1)'(mmdd_pkg::MAX_POINTS))) begin
                vals_o[pos[mmdd_pkg::PTR_BITS-1:0]] = cand_val[i];
                pos = pos + 1'b1;
            end
            if (i == 3) begin
                split = pos;
            end
        end
    end

    assign rec_o.load   = advance && ctl_i.valid && (pos != '0);
    assign rec_o.count  = pos[mmdd_pkg::PTR_BITS-1:0];
    assign rec_o.split  = split[mmdd_pkg::PTR_BITS-1:0];
    assign anchor_old_o = anchor_reg;
    assign anchor_new_o = anchor_next;

    // Column state; a trace's first sample always reopens it
    always_ff @(posedge aclk) begin
        if (advance && ctl_i.valid) begin
            col_reg    <= ctl_i.last ? '0 : col_next;
            anchor_reg <= anchor_next;
            first_reg  <= first_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            last_reg   <= last_next;
        end
    end

endmodule

// ===== src/mmdd_emit.sv =====
module mmdd_emit #(
    parameter int INDEX_BITS  = mmdd_pkg::INDEX_BITS_DEF,
    parameter int SAMPLE_BITS = mmdd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mmdd_pkg::rec_ctl_t            rec_i,
    input  logic signed [SAMPLE_BITS-1:0] vals_i [mmdd_pkg::MAX_POINTS],
    input  logic [INDEX_BITS-1:0]         anchor_old_i,
    input  logic [INDEX_BITS-1:0]         anchor_new_i,
    output logic                          free_o,
    output mmdd_pkg::emit_status_t        status_o,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [INDEX_BITS-1:0]         m_point_index,
    output logic signed [SAMPLE_BITS-1:0] m_point_value,
    output logic                          m_run_last
);

    logic                          busy_reg;
    logic [mmdd_pkg::PTR_BITS-1:0] ptr_reg;
    logic [mmdd_pkg::PTR_BITS-1:0] cnt_reg;
    logic [mmdd_pkg::PTR_BITS-1:0] split_reg;
    logic signed [SAMPLE_BITS-1:0] vals_reg [mmdd_pkg::MAX_POINTS];
    logic [INDEX_BITS-1:0]         anchor_old_reg;
    logic [INDEX_BITS-1:0]         anchor_new_reg;
    logic                          last_pt;

    assign last_pt = (ptr_reg == cnt_reg - 1'b1);
    assign free_o  = !busy_reg || (m_ready && last_pt);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ptr_reg  <= '0;
        end else if (rec_i.load) begin
            busy_reg <= 1'b1;
            ptr_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            if (last_pt) begin
                busy_reg <= 1'b0;
            end else begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_i.load) begin
            cnt_reg        <= rec_i.count;
            split_reg      <= rec_i.split;
            vals_reg       <= vals_i;
            anchor_old_reg <= anchor_old_i;
            anchor_new_reg <= anchor_new_i;
        end
    end

    assign m_valid       = busy_reg;
    assign m_point_value = vals_reg[ptr_reg];
    assign m_point_index = (ptr_reg < split_reg) ? anchor_old_reg : anchor_new_reg;
    assign m_run_last    = last_pt;

    assign status_o.busy  = busy_reg;
    assign status_o.ptr   = ptr_reg;
    assign status_o.count = cnt_reg;

endmodule

// ===== src/minmax_display_decimator.sv =====
// Min/max decimator for waveform display.
// Input beats (s_valid/s_ready) carry one sample each, in index order; a beat
// with s_end_of_trace closes the trace and flushes the open column. Output
// beats (m_valid/m_ready) carry polyline points: the column anchor index, the
// value, and m_run_last on the final point caused by one input beat. An input
// beat yields zero to five points.
// Points for a beat pass the input register, the multiply register and then
// the point record before they appear on the output.
// Throughput: one input beat per cycle while each beat yields at most one point
// and the receiver is ready; a beat that yields more points stalls the input
// once its record is loaded, since the single point record drains one point per
// cycle while the receiver is ready. The column multiply is registered once.
// Reset (aresetn, synchronous, active low) clears the handshake state and the
// trace state, and loads start_index = 0, pixels_per_sample = 0.5 (Q0.24).
// A receiver stall holds the pending point on the outputs and the whole
// pipeline; s_ready drops until the last pending point is taken. Users write
// configuration (cfg_wr_en/cfg_addr/cfg_wdata) only when idle; not enforced.
`include "minmax_display_decimator_assert.svh"

module minmax_display_decimator #(
    parameter int INDEX_BITS  = mmdd_pkg::INDEX_BITS_DEF,
    parameter int SAMPLE_BITS = mmdd_pkg::SAMPLE_BITS_DEF,
    localparam int CfgBits    = (INDEX_BITS > mmdd_pkg::RATIO_BITS) ?
                                INDEX_BITS : mmdd_pkg::RATIO_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mmdd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CfgBits-1:0]                 cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_value,
    input  logic                               s_end_of_trace,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [INDEX_BITS-1:0]              m_point_index,
    output logic signed [SAMPLE_BITS-1:0]      m_point_value,
    output logic                               m_run_last
);

    localparam int ProdBits = INDEX_BITS + mmdd_pkg::RATIO_BITS;

    logic [INDEX_BITS-1:0]           start_index_reg;
    logic [mmdd_pkg::RATIO_BITS-1:0] pps_reg;

    logic                            advance;
    logic                            front_primed;
    mmdd_pkg::beat_ctl_t             beat_ctl;
    logic [ProdBits-1:0]             beat_prod;
    logic [INDEX_BITS-1:0]           beat_idx;
    logic signed [SAMPLE_BITS-1:0]   beat_value;
    mmdd_pkg::rec_ctl_t              rec_ctl;
    logic signed [SAMPLE_BITS-1:0]   rec_vals [mmdd_pkg::MAX_POINTS];
    logic [INDEX_BITS-1:0]           anchor_old;
    logic [INDEX_BITS-1:0]           anchor_new;
    mmdd_pkg::emit_status_t          emit_status;

    // Register file; unknown indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_index_reg <= '0;
            pps_reg         <= mmdd_pkg::PPS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mmdd_pkg::REG_START_INDEX:       start_index_reg <= cfg_wdata[INDEX_BITS-1:0];
                mmdd_pkg::REG_PIXELS_PER_SAMPLE: pps_reg <= cfg_wdata[mmdd_pkg::RATIO_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances when the point record is free or drains now
    assign s_ready = advance;

    mmdd_front #(
        .INDEX_BITS  (INDEX_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .advance           (advance),
        .s_valid           (s_valid),
        .s_sample_value    (s_sample_value),
        .s_end_of_trace    (s_end_of_trace),
        .start_index       (start_index_reg),
        .pixels_per_sample (pps_reg),
        .ctl_o             (beat_ctl),
        .prod_o            (beat_prod),
        .idx_o             (beat_idx),
        .value_o           (beat_value),
        .primed_o          (front_primed)
    );

    mmdd_column #(
        .INDEX_BITS  (INDEX_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_column (
        .aclk         (aclk),
        .advance      (advance),
        .ctl_i        (beat_ctl),
        .prod_i       (beat_prod),
        .idx_i        (beat_idx),
        .value_i      (beat_value),
        .rec_o        (rec_ctl),
        .vals_o       (rec_vals),
        .anchor_old_o (anchor_old),
        .anchor_new_o (anchor_new)
    );

    mmdd_emit #(
        .INDEX_BITS  (INDEX_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rec_i         (rec_ctl),
        .vals_i        (rec_vals),
        .anchor_old_i  (anchor_old),
        .anchor_new_i  (anchor_new),
        .free_o        (advance),
        .status_o      (emit_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_index (m_point_index),
        .m_point_value (m_point_value),
        .m_run_last    (m_run_last)
    );

    // Pending record always points inside its own point list
    `MMDD_ASSERT_IMPL(a_ptr_in_range, aclk, aresetn, emit_status.busy,
        emit_status.ptr < emit_status.count && emit_status.count <= mmdd_pkg::MAX_COUNT)
    // Stalled receiver: hold the pending point
    `MMDD_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, emit_status.busy && !m_ready,
        emit_status.busy && $stable(emit_status.ptr))
    // End-of-trace beat rearms the index counter for a new trace
    `MMDD_ASSERT_NEXT(a_rearm_after_end, aclk, aresetn,
        s_valid && s_ready && s_end_of_trace, !front_primed)

endmodule

// ===== bench/minmax_point_check.sv =====
`timescale 1ns / 100ps

// Watches both channels and the register port, folds every accepted sample
// into a shadow of the column state, and compares each output beat against
// the oldest point still owed.
module minmax_point_check #(
    parameter int IB = mmdd_pkg::INDEX_BITS_DEF,
    parameter int SB = mmdd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mmdd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [mmdd_pkg::RATIO_BITS-1:0]    cfg_wdata,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [SB-1:0]               s_sample_value,
    input  logic                               s_end_of_trace,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [IB-1:0]                      m_point_index,
    input  logic signed [SB-1:0]               m_point_value,
    input  logic                               m_run_last,
    output int                                 failures,
    output int                                 points_pending
);
    import mmdd_pkg::*;

    typedef struct packed {
        logic [IB-1:0]        index;
        logic signed [SB-1:0] value;
        logic                 run_last;
    } point_t;

    // shadow registers
    logic [IB-1:0]         view_start;
    logic [RATIO_BITS-1:0] view_ratio;

    // shadow column state
    logic [IB-1:0]        sample_idx;
    logic [IB-1:0]        open_col;
    logic [IB-1:0]        anchor;
    logic signed [SB-1:0] col_first;
    logic signed [SB-1:0] col_min;
    logic signed [SB-1:0] col_max;
    logic signed [SB-1:0] col_last;
    logic                 primed;

    point_t points_due[$];
    point_t beat_points[$];

    initial failures = 0;
    initial points_pending = 0;

    // round-half-even column of a sample index
    function automatic logic [IB-1:0] column_at(input logic [IB-1:0] index);
        logic [IB-1:0]         delta;
        logic [63:0]           product;
        logic [63:0]           whole;
        logic [RATIO_BITS-1:0] frac;
        delta   = index - view_start;
        product = 64'(delta);
        product = product * view_ratio;
        whole   = product >> RATIO_BITS;
        frac    = product[RATIO_BITS-1:0];
        if (frac > RATIO_HALF || (frac == RATIO_HALF && whole[0]))
            whole = whole + 1;
        return whole[IB-1:0];
    endfunction

    function automatic void add_point(input logic signed [SB-1:0] v);
        point_t pt;
        pt.index    = anchor;
        pt.value    = v;
        pt.run_last = 1'b0;
        beat_points.insert(beat_points.size(), pt);
    endfunction

    function automatic void open_column(input logic [IB-1:0] index, input logic [IB-1:0] col,
                                        input logic signed [SB-1:0] v);
        anchor    = index;
        open_col  = col;
        col_first = v;
        col_min   = v;
        col_max   = v;
        col_last  = v;
    endfunction

    task automatic fold_sample(input logic signed [SB-1:0] v, input logic eot);
        logic [IB-1:0] idx;
        logic [IB-1:0] col;
        point_t        pt;
        beat_points.delete();
        if (!primed) begin
            sample_idx = view_start;
            open_column(sample_idx, '0, v);
            primed = 1'b1;
        end else begin
            idx = sample_idx + 1'b1;
            col = column_at(idx);
            sample_idx = idx;
            if (col != open_col) begin
                add_point(col_first);
                // a column ending at its minimum is drawn max before min
                if (col_last == col_min) begin
                    if (col_max != col_first) add_point(col_max);
                    if (col_min != col_max) add_point(col_min);
                end else begin
                    if (col_min != col_first) add_point(col_min);
                    if (col_max != col_min) add_point(col_max);
                    if (col_last != col_min) add_point(col_last);
                end
                open_column(idx, col, v);
            end else begin
                col_last = v;
                if (v < col_min) col_min = v;
                if (v > col_max) col_max = v;
            end
        end
        if (eot) begin
            add_point(col_first);
            if (col_min != col_first) add_point(col_min);
            if (col_max != col_min) add_point(col_max);
            if (col_last != col_min) add_point(col_last);
            primed     = 1'b0;
            open_col   = '0;
            sample_idx = view_start;
            anchor     = view_start;
        end
        for (int k = 0; k < beat_points.size(); k++) begin
            pt = beat_points[k];
            pt.run_last = (k == beat_points.size() - 1);
            points_due.insert(points_due.size(), pt);
        end
    endtask

    task automatic check_point();
        point_t want;
        if (points_due.size() == 0) begin
            $error("point with nothing owed: index %0d value %0d", m_point_index, m_point_value);
            failures++;
        end else begin
            want = points_due.pop_front();
            if (m_point_index !== want.index) begin
                $error("point_index: expected %0d, got %0d", want.index, m_point_index);
                failures++;
            end
            if (m_point_value !== want.value) begin
                $error("point_value: expected %0d, got %0d", want.value, m_point_value);
                failures++;
            end
            if (m_run_last !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, m_run_last);
                failures++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            view_start = '0;
            view_ratio = PPS_RESET;
            sample_idx = '0;
            open_col   = '0;
            anchor     = '0;
            col_first  = '0;
            col_min    = '0;
            col_max    = '0;
            col_last   = '0;
            primed     = 1'b0;
            points_due.delete();
            points_pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_START_INDEX:       view_start = cfg_wdata[IB-1:0];
                    REG_PIXELS_PER_SAMPLE: view_ratio = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                fold_sample(s_sample_value, s_end_of_trace);
            if (m_valid && m_ready)
                check_point();
            points_pending <= points_due.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the min/max display decimator. The checker beside
// the block does all prediction and comparison; this module only shapes the
// sample stream, the register writes and the backpressure.
module tb_top;
    import mmdd_pkg::*;

    // the two register indexes that map to nothing; writes there are dropped
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_HI = 2'd3;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

    localparam int ITEMS_PER_PHASE = 98;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0]   cfg_addr = '0;
    logic [RATIO_BITS-1:0]      cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [31:0]         s_sample_value = '0;
    logic                       s_end_of_trace = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [23:0]                m_point_index;
    logic signed [31:0]         m_point_value;
    logic                       m_run_last;

    int failures;
    int points_pending;

    // percentages of cycles the sender sits idle / the receiver stalls
    int idle_pct = 0;
    int stall_pct = 0;
    int samples_sent = 0;

    always #2 aclk = ~aclk;

    minmax_display_decimator u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_end_of_trace (s_end_of_trace),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_index  (m_point_index),
        .m_point_value  (m_point_value),
        .m_run_last     (m_run_last)
    );

    minmax_point_check u_points (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_end_of_trace (s_end_of_trace),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_index  (m_point_index),
        .m_point_value  (m_point_value),
        .m_run_last     (m_run_last),
        .failures       (failures),
        .points_pending (points_pending)
    );

    // Receiver: stall at random at the current rate; with a zero rate ready
    // stays high for whole stretches.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one sample beat and hold it until accepted. Valid stays high on
    // return so a follow-on beat can go out back to back; whoever pauses
    // next drops it.
    task automatic send_sample(input logic signed [31:0] v, input logic eot);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_value <= v;
        s_end_of_trace <= eot;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // Drop valid, wait until every owed point has come out, then let the
    // pipeline run on idle in case the last beat produced no point.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (points_pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [RATIO_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [23:0] pick_start();
        case ($urandom_range(3))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'hFFFFFF - 24'($urandom_range(15));  // wrap within the trace
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_ratio();
        case ($urandom_range(6))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return PPS_RESET;
            3:       return 24'h555555;
            4:       return 24'($urandom_range(24'h400000, 24'h100000));
            default: return 24'($urandom);
        endcase
    endfunction

    // Change one or both registers, or poke an unmapped index.
    task automatic retune();
        case ($urandom_range(4))
            0: write_reg(REG_START_INDEX, pick_start());
            1: write_reg(REG_PIXELS_PER_SAMPLE, pick_ratio());
            2: begin
                write_reg(REG_START_INDEX, pick_start());
                write_reg(REG_PIXELS_PER_SAMPLE, pick_ratio());
            end
            3: write_reg(REG_PIXELS_PER_SAMPLE, pick_ratio());
            default: write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                               24'($urandom));
        endcase
    endtask

    // One trace with random content. Most end on the end marker; a few run
    // on into the next trace. Now and then the registers change mid-trace.
    task automatic run_trace();
        int                 len;
        int                 mode;
        int                 retune_at;
        logic signed [31:0] base;
        logic signed [31:0] v;
        logic               eot;
        len       = ($urandom_range(7) == 0) ? $urandom_range(48, 20) : $urandom_range(14, 1);
        mode      = $urandom_range(3);
        base      = $urandom;
        retune_at = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : 0;
        for (int k = 0; k < len; k++) begin
            if (retune_at != 0 && k == retune_at) begin
                settle();
                retune();
            end
            case (mode)
                0: v = $urandom;
                1: v = int'($urandom_range(6)) - 3;   // narrow range: many repeats
                2: begin
                    case ($urandom_range(3))
                        0:       v = VAL_MAX;
                        1:       v = VAL_MIN;
                        2:       v = 0;
                        default: v = -1;
                    endcase
                end
                default: v = ($urandom_range(3) == 0) ? $urandom : base;
            endcase
            eot = (k == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
            send_sample(v, eot);
        end
    endtask

    initial begin
        logic signed [31:0] shaped [12];
        shaped = '{10, -3, 7, 4, 9, 2, 1, VAL_MIN, VAL_MAX, 5, 3, -1};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, no idling.
        // Lone end-marked samples at both extremes: one point each.
        send_sample(VAL_MAX, 1'b1);
        send_sample(VAL_MIN, 1'b1);
        settle();

        // Quarter ratio: columns of 3, 3 and 5 samples. The second column ends
        // on its minimum (max before min); the end-marked sample opens a new
        // column, so that beat yields five points.
        write_reg(REG_PIXELS_PER_SAMPLE, 24'h400000);
        for (int k = 0; k < 12; k++)
            send_sample(shaped[k], k == 11);
        settle();

        // Flat trace: repeated values collapse to one point per column.
        write_reg(REG_PIXELS_PER_SAMPLE, PPS_RESET);
        send_sample(7, 1'b0);
        send_sample(7, 1'b0);
        send_sample(7, 1'b0);
        send_sample(7, 1'b1);
        settle();

        // Zero ratio: a single column for the whole trace.
        write_reg(REG_PIXELS_PER_SAMPLE, 24'h000000);
        send_sample(-5, 1'b0);
        send_sample(9, 1'b0);
        send_sample(0, 1'b1);
        settle();

        // Widest ratio with the origin just below the wrap; also poke both
        // unmapped indexes, which must change nothing.
        write_reg(REG_START_INDEX, 24'hFFFFFE);
        write_reg(REG_PIXELS_PER_SAMPLE, 24'hFFFFFF);
        write_reg(REG_SPARE_LO, 24'($urandom));
        write_reg(REG_SPARE_HI, 24'($urandom));
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(VAL_MIN, 1'b0);
        send_sample(VAL_MAX, 1'b1);
        settle();
        write_reg(REG_START_INDEX, 24'h000000);
        write_reg(REG_PIXELS_PER_SAMPLE, PPS_RESET);

        // Random part over four backpressure phases: none, sender idle,
        // receiver stalling, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 70; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 70; end
                default: begin idle_pct = 36; stall_pct <= 36; end
            endcase
            while (samples_sent < 25 + (phase + 1) * ITEMS_PER_PHASE) begin
                if ($urandom_range(2) == 0) begin
                    settle();
                    retune();
                end
                run_trace();
            end
        end

        // Close any open trace, then drain.
        send_sample($urandom, 1'b1);
        settle();
        if (failures == 0)
            $display("PASS minmax_display_decimator");
        else
            $display("FAIL minmax_display_decimator");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("FAIL minmax_display_decimator");
        $finish;
    end

endmodule
